[rtl/vfcm_pkg.sv]
package vfcm_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_VOXEL = 2'd0,
    OP_WRITE_TYPE  = 2'd1,
    OP_MESH        = 2'd2,
    OP_NOP         = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_NREAD,
    ST_NCHECK,
    ST_NDECIDE,
    ST_TILE,
    ST_EMIT
  } state_e;

  localparam int unsigned NUM_FACES = 6;
  localparam int unsigned FACE_VERTS = 6;
  // tiles per atlas row; a power of two so the uv split is a mask and a shift
  localparam int unsigned ATLAS_TILES = 16;
  localparam logic [14:0] SHADE_STEP = 15'd273;
  localparam logic [7:0] TILE_TOP = 8'd255;

  // corner bits per face and vertex: {dx, dy, dz, u, v}
  function automatic logic [4:0] corner(input logic [2:0] f, input logic [2:0] k);
    logic [4:0] c;
    c = 5'b0;
    case (f)
      3'd0: case (k)
        3'd0, 3'd3: c = 5'b10000;
        3'd1: c = 5'b10110;
        3'd2, 3'd4: c = 5'b11111;
        3'd5: c = 5'b11001;
        default: c = 5'b0;
      endcase
      3'd1: case (k)
        3'd0, 3'd3: c = 5'b00100;
        3'd1: c = 5'b00010;
        3'd2, 3'd4: c = 5'b01011;
        3'd5: c = 5'b01101;
        default: c = 5'b0;
      endcase
      3'd2: case (k)
        3'd0, 3'd3: c = 5'b01000;
        3'd1: c = 5'b11010;
        3'd2, 3'd4: c = 5'b11111;
        3'd5: c = 5'b01101;
        default: c = 5'b0;
      endcase
      3'd3: case (k)
        3'd0, 3'd3: c = 5'b00000;
        3'd1: c = 5'b10010;
        3'd2, 3'd4: c = 5'b10111;
        3'd5: c = 5'b00101;
        default: c = 5'b0;
      endcase
      3'd4: case (k)
        3'd0, 3'd3: c = 5'b10100;
        3'd1: c = 5'b00110;
        3'd2, 3'd4: c = 5'b01111;
        3'd5: c = 5'b11101;
        default: c = 5'b0;
      endcase
      3'd5: case (k)
        3'd0, 3'd3: c = 5'b00000;
        3'd1: c = 5'b10010;
        3'd2, 3'd4: c = 5'b11011;
        3'd5: c = 5'b01001;
        default: c = 5'b0;
      endcase
      default: c = 5'b0;
    endcase
    return c;
  endfunction

endpackage

[rtl/vfcm_chunk_mem.sv]
module vfcm_chunk_mem #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/vfcm_type_mem.sv]
module vfcm_type_mem #(
  parameter int unsigned IDW = 8
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [IDW-1:0] wid_i,
  input  logic [2:0]     wface_i,
  input  logic [7:0]     wtile_i,
  input  logic           wsee_i,
  input  logic [IDW-1:0] trans_id_i,
  output logic           trans_o,
  input  logic [IDW-1:0] tile_id_i,
  input  logic [2:0]     tile_face_i,
  output logic [7:0]     tile_o
);
  logic           trans_mem [2**IDW];
  logic [7:0]     tile_mem  [2**IDW][vfcm_pkg::NUM_FACES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      trans_mem[wid_i] <= wsee_i;
      if (wface_i < 3'(vfcm_pkg::NUM_FACES)) begin
        tile_mem[wid_i][wface_i] <= wtile_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    trans_o <= trans_mem[trans_id_i];
    tile_o  <= tile_mem[tile_id_i][(tile_face_i < 3'(vfcm_pkg::NUM_FACES)) ? tile_face_i : 3'd0];
  end
endmodule

[rtl/voxel_face_cull_mesher.sv]
// Culled voxel face mesher; chunk ids and type tables sit in sync-read RAMs.
// Writes (voxel, type entry, no-op) take one beat each and may follow back to back.
// Mesh: a center read, a neighbor scan of three states per face (read, check, decide),
// then per face up to the last open one a tile read plus 6 vertex beats if the face
// is open. An empty cell ends after the center read and a cell with no open face
// after the scan. Reset clears control only.
module voxel_face_cull_mesher #(
  parameter int unsigned CHUNK_EDGE  = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0] cell_x[5:2] cell_y[9:6] cell_z[13:10] voxel_value[21:14]
  // face_select[24:22] tile_index[32:25] see_through[33], zero fill to 40
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // vert_x[4:0] vert_y[9:5] vert_z[14:10] tex_u[19:15] tex_v[24:20]
  // shade_word[39:25] face_code[42:40], zero fill to 48
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  localparam int unsigned CB = (CHUNK_EDGE > 1) ? $clog2(CHUNK_EDGE) : 1;
  localparam int unsigned AW = 3 * CB;

  vfcm_pkg::state_e state_q, state_d;

  // input fields
  logic [1:0] in_op;
  logic [3:0] in_x, in_y, in_z;
  logic [7:0] in_val, in_tile;
  logic [2:0] in_face;
  logic in_see, in_inside, accept;
  logic [ID_BITS-1:0] in_id;
  assign in_op   = s_axis_tdata[1:0];
  assign in_x    = s_axis_tdata[5:2];
  assign in_y    = s_axis_tdata[9:6];
  assign in_z    = s_axis_tdata[13:10];
  assign in_val  = s_axis_tdata[21:14];
  assign in_face = s_axis_tdata[24:22];
  assign in_tile = s_axis_tdata[32:25];
  assign in_see  = s_axis_tdata[33];
  assign in_id   = ID_BITS'(in_val);
  assign in_inside = (5'(in_x) < 5'(CHUNK_EDGE)) && (5'(in_y) < 5'(CHUNK_EDGE))
                  && (5'(in_z) < 5'(CHUNK_EDGE));
  assign accept = s_axis_tvalid && s_axis_tready;

  // job registers
  logic [CB-1:0] x_q, y_q, z_q;
  logic [ID_BITS-1:0] vid_q;
  logic [2:0] face_q, vert_q;
  logic open_q, nbr_air_q;
  // faces found open by the scan, bit per face code
  logic [5:0] open_mask_q;

  // neighbor address
  logic [CB-1:0] nx, ny, nz;
  logic border;
  always_comb begin
    nx = x_q; ny = y_q; nz = z_q; border = 1'b0;
    case (face_q)
      3'd0: begin border = (x_q == CB'(CHUNK_EDGE - 1)); nx = x_q + CB'(1); end
      3'd1: begin border = (x_q == '0); nx = x_q - CB'(1); end
      3'd2: begin border = (y_q == CB'(CHUNK_EDGE - 1)); ny = y_q + CB'(1); end
      3'd3: begin border = (y_q == '0); ny = y_q - CB'(1); end
      3'd4: begin border = (z_q == CB'(CHUNK_EDGE - 1)); nz = z_q + CB'(1); end
      default: begin border = (z_q == '0); nz = z_q - CB'(1); end
    endcase
  end

  // chunk store: writes only while idle, so the mesh reads never overlap a write
  logic cm_we;
  logic [AW-1:0] cm_waddr, cm_raddr;
  logic [ID_BITS-1:0] cm_rdata;
  assign cm_we = accept && (in_op == vfcm_pkg::OP_WRITE_VOXEL) && in_inside;
  assign cm_waddr = {in_z[CB-1:0], in_y[CB-1:0], in_x[CB-1:0]};
  assign cm_raddr = (state_q == vfcm_pkg::ST_IDLE)
                  ? {in_z[CB-1:0], in_y[CB-1:0], in_x[CB-1:0]} : {nz, ny, nx};

  vfcm_chunk_mem #(.AW(AW), .DW(ID_BITS)) u_chunk (
    .clk_i, .we_i(cm_we), .waddr_i(cm_waddr), .wdata_i(in_id),
    .raddr_i(cm_raddr), .rdata_o(cm_rdata)
  );

  // type tables: flag looked up by the neighbor id, tile by the cell id and face
  logic tm_we, tm_trans;
  logic [7:0] tm_tile;
  assign tm_we = accept && (in_op == vfcm_pkg::OP_WRITE_TYPE);

  vfcm_type_mem #(.IDW(ID_BITS)) u_type (
    .clk_i, .we_i(tm_we), .wid_i(in_id), .wface_i(in_face),
    .wtile_i(in_tile), .wsee_i(in_see), .trans_id_i(cm_rdata), .trans_o(tm_trans),
    .tile_id_i(vid_q), .tile_face_i(face_q), .tile_o(tm_tile)
  );

  logic last_face, last_vert, face_open, more_faces;
  logic [5:0] mask_now;
  logic [4:0] later;
  assign last_face = (face_q == 3'(vfcm_pkg::NUM_FACES - 1));
  assign last_vert = (vert_q == 3'(vfcm_pkg::FACE_VERTS - 1));
  // a border face is drawn regardless of the wrapped neighbor read
  assign face_open = open_q || nbr_air_q || tm_trans;
  assign mask_now = open_mask_q | (6'(face_open) << face_q);
  // open faces above the current one; none left means this face ends the run
  assign later = 5'(open_mask_q >> (face_q + 3'd1));
  assign more_faces = |later;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vfcm_pkg::ST_IDLE:
        if (accept && in_op == vfcm_pkg::OP_MESH && in_inside) state_d = vfcm_pkg::ST_CENTER;
      vfcm_pkg::ST_CENTER:
        state_d = (cm_rdata == '0) ? vfcm_pkg::ST_IDLE : vfcm_pkg::ST_NREAD;
      vfcm_pkg::ST_NREAD:  state_d = vfcm_pkg::ST_NCHECK;
      vfcm_pkg::ST_NCHECK: state_d = vfcm_pkg::ST_NDECIDE;
      vfcm_pkg::ST_NDECIDE: begin
        if (!last_face) state_d = vfcm_pkg::ST_NREAD;
        else if (mask_now == '0) state_d = vfcm_pkg::ST_IDLE;
        else state_d = vfcm_pkg::ST_TILE;
      end
      vfcm_pkg::ST_TILE:
        if (open_mask_q[face_q]) state_d = vfcm_pkg::ST_EMIT;
      vfcm_pkg::ST_EMIT:
        if (m_axis_tready && last_vert)
          state_d = more_faces ? vfcm_pkg::ST_TILE : vfcm_pkg::ST_IDLE;
      default: state_d = vfcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vfcm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // scan pass fills the open mask, emit pass walks the faces again in order
  always_ff @(posedge clk_i) begin
    case (state_q)
      vfcm_pkg::ST_IDLE: begin
        x_q <= in_x[CB-1:0]; y_q <= in_y[CB-1:0]; z_q <= in_z[CB-1:0];
        face_q <= '0; open_mask_q <= '0;
      end
      vfcm_pkg::ST_CENTER: vid_q <= cm_rdata;
      vfcm_pkg::ST_NREAD: open_q <= border;
      vfcm_pkg::ST_NCHECK: nbr_air_q <= (cm_rdata == '0);
      vfcm_pkg::ST_NDECIDE: begin
        open_mask_q <= mask_now;
        face_q <= last_face ? 3'd0 : face_q + 3'd1;
      end
      vfcm_pkg::ST_TILE: begin
        // tile read for face_q is issued here and valid in the first emit cycle
        vert_q <= '0;
        if (!open_mask_q[face_q]) face_q <= face_q + 3'd1;
      end
      vfcm_pkg::ST_EMIT:
        if (m_axis_tready) begin
          vert_q <= vert_q + 3'd1;
          if (last_vert) face_q <= face_q + 3'd1;
        end
      default: ;
    endcase
  end

  // vertex beat, built from registers only so it holds while the sink stalls
  logic [42:0] cur_beat;
  logic [4:0] cc;
  logic [14:0] shade;
  logic [4:0] tu, tv;
  always_comb begin
    cc = vfcm_pkg::corner(face_q, vert_q);
    shade = (15'(5'd16 - 5'(x_q)) * vfcm_pkg::SHADE_STEP) + {face_q, 12'h000};
    tu = 5'(tm_tile % 8'(vfcm_pkg::ATLAS_TILES)) + 5'(cc[1]);
    tv = 5'((vfcm_pkg::TILE_TOP - tm_tile) / 8'(vfcm_pkg::ATLAS_TILES)) + 5'(cc[0]);
    cur_beat = {face_q, shade, tv, tu, 5'(z_q) + 5'(cc[2]), 5'(y_q) + 5'(cc[3]),
                5'(x_q) + 5'(cc[4])};
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == vfcm_pkg::ST_IDLE);
    m_axis_tvalid = (state_q == vfcm_pkg::ST_EMIT);
    m_axis_tlast  = m_axis_tvalid && last_vert && !more_faces;
    m_axis_tdata  = {5'b0, cur_beat};
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != vfcm_pkg::ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
    (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("beat changed");
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vfcm_pkg::ST_EMIT) |-> (face_q < 3'd6)) else $error("bad face");
`endif
endmodule

[tb/voxel_face_cull_mesher_test.sv]
module voxel_face_cull_mesher_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the mesher: chunk ids, type flags and tiles, plus the queue of
  // vertices still owed by the block.
  class mesh_scoreboard;
    typedef struct {
      bit [4:0]  x, y, z, u, v;
      bit [14:0] shade;
      bit [2:0]  face;
      bit        last;
    } vertex_t;

    bit [7:0] vox_ids [4096];
    bit       vox_set [4096];
    bit       see_thru [256];
    bit       see_set [256];
    bit [7:0] face_tile [256][6];
    bit       tile_set [256][6];
    vertex_t  owed_verts [$];
    int       errors;
    int       vert_count;
    int       mesh_count;

    // per face, per vertex: {dx, dy, dz, u, v}
    bit [4:0] corners [6][6] = '{
      '{5'b10000, 5'b10110, 5'b11111, 5'b10000, 5'b11111, 5'b11001},
      '{5'b00100, 5'b00010, 5'b01011, 5'b00100, 5'b01011, 5'b01101},
      '{5'b01000, 5'b11010, 5'b11111, 5'b01000, 5'b11111, 5'b01101},
      '{5'b00000, 5'b10010, 5'b10111, 5'b00000, 5'b10111, 5'b00101},
      '{5'b10100, 5'b00110, 5'b01111, 5'b10100, 5'b01111, 5'b11101},
      '{5'b00000, 5'b10010, 5'b11011, 5'b00000, 5'b11011, 5'b01001}
    };

    function int vox_at(int x, int y, int z);
      return x + 16 * y + 256 * z;
    endfunction

    // neighbor across face f; 0 when the face is on the chunk border
    function bit across(int x, int y, int z, int f, output int n);
      int c [3];
      int a;
      c[0] = x; c[1] = y; c[2] = z;
      a = f >> 1;
      n = 0;
      if (f % 2 == 0) begin
        if (c[a] == 15) return 0;
        c[a]++;
      end else begin
        if (c[a] == 0) return 0;
        c[a]--;
      end
      n = vox_at(c[0], c[1], c[2]);
      return 1;
    endfunction

    // true when meshing this spot reads only entries already written
    function bit mesh_safe(int x, int y, int z);
      int n;
      int i;
      bit [7:0] vid;
      i = vox_at(x, y, z);
      if (!vox_set[i]) return 0;
      vid = vox_ids[i];
      if (!see_set[vid]) return 0;
      for (int f = 0; f < 6; f++) begin
        if (!tile_set[vid][f]) return 0;
        if (across(x, y, z, f, n)) begin
          if (!vox_set[n]) return 0;
          if (!see_set[vox_ids[n]]) return 0;
        end
      end
      return 1;
    endfunction

    function void note_input(logic [39:0] d);
      vfcm_pkg::opcode_e op;
      int        x, y, z, n, tu, tv;
      bit [7:0]  val, t, vid;
      bit [2:0]  fsel;
      vertex_t   vt;
      vertex_t   run [$];
      op   = vfcm_pkg::opcode_e'(d[1:0]);
      x    = d[5:2];
      y    = d[9:6];
      z    = d[13:10];
      val  = d[21:14];
      fsel = d[24:22];
      t    = d[32:25];
      case (op)
        vfcm_pkg::OP_WRITE_VOXEL: begin
          vox_ids[vox_at(x, y, z)] = val;
          vox_set[vox_at(x, y, z)] = 1;
        end
        vfcm_pkg::OP_WRITE_TYPE: begin
          see_thru[val] = d[33];
          see_set[val]  = 1;
          if (fsel < 6) begin
            face_tile[val][fsel] = t;
            tile_set[val][fsel]  = 1;
          end
        end
        vfcm_pkg::OP_MESH: begin
          mesh_count++;
          vid = vox_ids[vox_at(x, y, z)];
          if (vid != 0) begin
            for (int f = 0; f < 6; f++) begin
              if (across(x, y, z, f, n))
                if (vox_ids[n] != 0 && !see_thru[vox_ids[n]]) continue;
              tu = face_tile[vid][f] % 16;
              tv = (255 - face_tile[vid][f]) / 16;
              for (int k = 0; k < 6; k++) begin
                vt.x     = 5'(x + corners[f][k][4]);
                vt.y     = 5'(y + corners[f][k][3]);
                vt.z     = 5'(z + corners[f][k][2]);
                vt.u     = 5'(tu + corners[f][k][1]);
                vt.v     = 5'(tv + corners[f][k][0]);
                vt.shade = 15'((16 - x) * 273 + f * 'h1000);
                vt.face  = 3'(f);
                vt.last  = 0;
                run.insert(run.size(), vt);
              end
            end
            if (run.size() > 0) run[run.size() - 1].last = 1;
            foreach (run[i]) owed_verts.insert(owed_verts.size(), run[i]);
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("vertex %0d: %s", vert_count, msg);
      errors++;
    endtask

    task check(logic [47:0] d, logic last);
      vertex_t w;
      if (owed_verts.size() == 0) begin
        report($sformatf("unexpected vertex beat %h", d));
        return;
      end
      w = owed_verts.pop_front();
      if (d[4:0] !== w.x)
        report($sformatf("vert_x got %0d want %0d", d[4:0], w.x));
      if (d[9:5] !== w.y)
        report($sformatf("vert_y got %0d want %0d", d[9:5], w.y));
      if (d[14:10] !== w.z)
        report($sformatf("vert_z got %0d want %0d", d[14:10], w.z));
      if (d[19:15] !== w.u)
        report($sformatf("tex_u got %0d want %0d", d[19:15], w.u));
      if (d[24:20] !== w.v)
        report($sformatf("tex_v got %0d want %0d", d[24:20], w.v));
      if (d[39:25] !== w.shade)
        report($sformatf("shade_word got %0d want %0d", d[39:25], w.shade));
      if (d[42:40] !== w.face)
        report($sformatf("face_code got %0d want %0d", d[42:40], w.face));
      if (last !== w.last)
        report($sformatf("last_vertex got %0d want %0d", last, w.last));
      vert_count++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  mesh_scoreboard sb;
  int             beats_sent;
  int             src_gap_pct;
  int             snk_gap_pct;
  bit [7:0]       id_pool [4] = '{8'd0, 8'd1, 8'd170, 8'd255};

  voxel_face_cull_mesher u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous cap: ~400 beats of worst-case mesh under heavy stall is well below
  initial begin
    #5ms;
    $display("voxel_face_cull_mesher: mismatch");
    $finish;
  end

  function automatic logic [39:0] pack_beat(vfcm_pkg::opcode_e op, int x, int y, int z,
                                            bit [7:0] val, bit [2:0] fsel,
                                            bit [7:0] tile, bit see);
    return {6'b0, see, tile, fsel, val, 4'(z), 4'(y), 4'(x), op};
  endfunction

  function automatic bit [7:0] pick_id();
    return id_pool[$urandom_range(3)];
  endfunction

  // idle mix moves with the beat count: slow receiver, then slow sender, then none
  task send_beat(logic [39:0] d);
    if (beats_sent < 130) begin
      src_gap_pct = 20; snk_gap_pct = 70;
    end else if (beats_sent < 260) begin
      src_gap_pct = 70; snk_gap_pct = 20;
    end else begin
      src_gap_pct = 0;  snk_gap_pct = 0;
    end
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(d);
    beats_sent++;
  endtask

  task put_voxel(int x, int y, int z, bit [7:0] id);
    send_beat(pack_beat(vfcm_pkg::OP_WRITE_VOXEL, x, y, z, id, 3'($urandom_range(7)),
                        8'($urandom_range(255)), 1'($urandom_range(1))));
  endtask

  task mesh_at(int x, int y, int z);
    send_beat(pack_beat(vfcm_pkg::OP_MESH, x, y, z, 8'($urandom_range(255)),
                        3'($urandom_range(7)), 8'($urandom_range(255)),
                        1'($urandom_range(1))));
  endtask

  // write a cell and its neighbors inside the chunk, then mesh it
  // mode: 0 air around, 1 opaque around, 2 random ids around
  task build_and_mesh(int x, int y, int z, bit [7:0] id, int mode);
    int n;
    put_voxel(x, y, z, id);
    for (int f = 0; f < 6; f++) begin
      if (sb.across(x, y, z, f, n))
        put_voxel(n % 16, (n / 16) % 16, n / 256,
                  mode == 0 ? 8'd0 : mode == 1 ? 8'd1 : pick_id());
    end
    mesh_at(x, y, z);
  endtask

  function automatic int any_coord();
    return ($urandom_range(99) < 30) ? ($urandom_range(1) ? 15 : 0) : $urandom_range(15);
  endfunction

  // receiver: check at each handshake, then redraw ready
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= ($urandom_range(99) >= snk_gap_pct);
    end
  end

  initial begin
    int r, i, guard;
    sb            = new();
    beats_sent    = 0;
    src_gap_pct   = 20;
    snk_gap_pct   = 70;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // type table: air flag via out-of-range face, full entries for the id pool
    send_beat(pack_beat(vfcm_pkg::OP_WRITE_TYPE, 0, 0, 0, 8'd0, 3'd7, 8'd255, 1'b0));
    for (int f = 0; f < 6; f++) begin
      send_beat(pack_beat(vfcm_pkg::OP_WRITE_TYPE, 0, 0, 0, 8'd1, 3'(f),
                          f == 0 ? 8'd0 : 8'd255, 1'b0));
      send_beat(pack_beat(vfcm_pkg::OP_WRITE_TYPE, 15, 15, 15, 8'd170, 3'(f),
                          8'($urandom_range(255)), 1'b1));
      send_beat(pack_beat(vfcm_pkg::OP_WRITE_TYPE, 0, 0, 0, 8'd255, 3'(f),
                          8'(16 * f + 15), 1'b0));
    end
    send_beat(pack_beat(vfcm_pkg::OP_WRITE_TYPE, 0, 0, 0, 8'd255, 3'd6, 8'd0, 1'b0));
    send_beat(pack_beat(vfcm_pkg::OP_NOP, 15, 15, 15, 8'd255, 3'd7, 8'd255, 1'b1));

    build_and_mesh(0, 0, 0, 8'd255, 0);     // low corner, all faces open
    build_and_mesh(15, 15, 15, 8'd1, 0);    // high corner
    build_and_mesh(8, 7, 9, 8'd255, 1);     // fully enclosed: nothing out
    build_and_mesh(3, 12, 5, 8'd170, 2);    // mixed neighbors
    put_voxel(4, 4, 4, 8'd0);
    mesh_at(4, 4, 4);                       // empty cell

    while (beats_sent < 380) begin
      r = $urandom_range(99);
      if (r < 45) begin
        build_and_mesh(any_coord(), any_coord(), any_coord(), pick_id(), 2);
      end else if (r < 60) begin
        send_beat(pack_beat(vfcm_pkg::OP_WRITE_TYPE, $urandom_range(15),
                            $urandom_range(15), $urandom_range(15),
                            ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : pick_id(),
                            3'($urandom_range(7)), 8'($urandom_range(255)),
                            1'($urandom_range(1))));
      end else if (r < 85) begin
        i = $urandom_range(4095);
        if (sb.mesh_safe(i % 16, (i / 16) % 16, i / 256)) mesh_at(i % 16, (i / 16) % 16, i / 256);
        else put_voxel(i % 16, (i / 16) % 16, i / 256, pick_id());
      end else if (r < 95) begin
        put_voxel(any_coord(), any_coord(), any_coord(), pick_id());
      end else begin
        send_beat(pack_beat(vfcm_pkg::OP_NOP, $urandom_range(15), $urandom_range(15),
                            $urandom_range(15), 8'($urandom_range(255)),
                            3'($urandom_range(7)), 8'($urandom_range(255)),
                            1'($urandom_range(1))));
      end
    end
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (sb.owed_verts.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (80) @(posedge clk_i);

    $display("covered %0d beats, %0d mesh requests, %0d vertices checked",
             beats_sent, sb.mesh_count, sb.vert_count);
    if (sb.errors == 0 && sb.owed_verts.size() == 0) begin
      $display("voxel_face_cull_mesher: match");
    end else begin
      $display("%0d errors, %0d vertices never seen", sb.errors, sb.owed_verts.size());
      $display("voxel_face_cull_mesher: mismatch");
    end
    $finish;
  end

endmodule
